FILE: rtl/core/ajb_pkg.sv
// ----------------------------------------------------------------------------
// Audio jitter buffer package
// Shared constants, codes and payload types of the jitter buffer controller.
// ----------------------------------------------------------------------------
package ajb_pkg;

   // Ring geometry and frame size.
   localparam int QUEUE_SLOTS = 16;
   localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
   localparam int FILL_W      = SLOT_W + 1;
   localparam int FRAME_BYTES = 1024;

   // Volume limits and reset value.
   localparam logic [7:0] VOLUME_MAX         = 8'd100;
   localparam logic [7:0] START_VOLUME_RESET = 8'd50;

   // Configuration reset values.
   localparam logic [3:0]  JITTER_TARGET_RESET = 4'd4;
   localparam logic [4:0]  LATENCY_MAX_RESET   = 5'd8;
   localparam logic [31:0] PACKET_MAGIC_RESET  = 32'd0;

   typedef enum logic [1:0] {
      ACT_PACKET = 2'd0,
      ACT_TICK   = 2'd1,
      ACT_VOLUME = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      KIND_ACCEPT  = 2'd0,
      KIND_REJECT  = 2'd1,
      KIND_FRAME   = 2'd2,
      KIND_SILENCE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_JITTER_TARGET = 2'd0,
      CSR_LATENCY_MAX   = 2'd1,
      CSR_PACKET_MAGIC  = 2'd2,
      CSR_START_VOLUME  = 2'd3
   } csr_index_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] header_magic;
      logic [15:0] payload_length;
      logic [7:0]  volume_level;
      logic [31:0] sequence_number;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  slot;
      logic [15:0] frame_length;
      logic [31:0] frame_sequence;
      logic [7:0]  applied_level;
      logic [4:0]  queue_depth;
      logic [4:0]  dropped_now;
      logic [31:0] received_total;
      logic [31:0] dropped_total;
      logic [31:0] played_total;
      logic [31:0] silence_total;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  jitter_target;
      logic [4:0]  latency_max;
      logic [31:0] packet_magic;
   } cfg_type;

   // One ring entry: descriptor of a queued frame.
   typedef struct packed {
      logic [31:0] seq_num;
      logic [15:0] byte_len;
   } slot_entry_type;

endpackage

FILE: rtl/core/ajb_slot_ram.sv
// ----------------------------------------------------------------------------
// Slot descriptor RAM
// Single-port-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ajb_slot_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/ajb_csr.sv
// ----------------------------------------------------------------------------
// Jitter buffer configuration registers
// Holds the target depth, latency limit and packet magic word.
// ----------------------------------------------------------------------------
module ajb_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  ajb_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata,
   output ajb_pkg::cfg_type       cfg
);
   import ajb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Start volume only matters at reset, and reset restores its default, so a
   // write to it is accepted and has no lasting effect.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_JITTER_TARGET: cfg_in.jitter_target = csr_wdata[3:0];
            CSR_LATENCY_MAX:   cfg_in.latency_max   = csr_wdata[4:0];
            CSR_PACKET_MAGIC:  cfg_in.packet_magic  = csr_wdata;
            CSR_START_VOLUME:  cfg_in = cfg_ff;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jitter_target <= JITTER_TARGET_RESET;
         cfg_ff.latency_max   <= LATENCY_MAX_RESET;
         cfg_ff.packet_magic  <= PACKET_MAGIC_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

FILE: rtl/core/ajb_engine.sv
// ----------------------------------------------------------------------------
// Jitter buffer engine
// Takes one request at a time, reads the head slot, then updates the ring.
// ----------------------------------------------------------------------------
module ajb_engine (
   input  logic             clock,
   input  logic             reset,
   input  ajb_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  ajb_pkg::req_type req_data,
   input  logic             rsp_free,
   output logic             res_valid,
   output ajb_pkg::rsp_type res_data
);
   import ajb_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              buffering_ff, buffering_in;
   logic [7:0]        cur_vol_ff, cur_vol_in;
   logic [7:0]        app_vol_ff, app_vol_in;
   logic              pending_ff, pending_in;
   logic [31:0]       rx_cnt_ff, rx_cnt_in;
   logic [31:0]       drop_cnt_ff, drop_cnt_in;
   logic [31:0]       play_cnt_ff, play_cnt_in;
   logic [31:0]       sil_cnt_ff, sil_cnt_in;

   logic              accept;
   logic              wr_en;
   slot_entry_type    wr_entry;
   slot_entry_type    rd_entry;
   logic [$bits(slot_entry_type)-1:0] rd_raw;

   // Packet path terms.
   logic              pkt_ok;
   logic [FILL_W-1:0] lat_m1;
   logic [FILL_W-1:0] limit;
   logic              trim;
   logic [FILL_W-1:0] drops_trim;
   logic [FILL_W-1:0] fill_trim;
   logic [SLOT_W-1:0] head_trim;
   logic [SLOT_W-1:0] wslot;
   logic              ring_full;
   logic [FILL_W-1:0] drops_all;

   // Tick path terms.
   logic              apply_vol;
   logic              hold;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign req_stall = (state_ff != ST_IDLE);

   // The head slot is read while the request is accepted, so its descriptor is
   // ready in the evaluation cycle. Writes happen only in that later cycle.
   ajb_slot_ram #(
      .DEPTH (QUEUE_SLOTS),
      .WIDTH ($bits(slot_entry_type))
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wslot),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (rd_raw)
   );

   assign rd_entry = slot_entry_type'(rd_raw);

   always_comb begin
      pkt_ok = (req_ff.header_magic == cfg.packet_magic) &&
               (req_ff.payload_length != 16'd0) &&
               (req_ff.payload_length <= 16'(FRAME_BYTES));

      lat_m1 = cfg.latency_max - FILL_W'(1);
      if (cfg.latency_max == '0) begin
         limit = '0;
      end else if (lat_m1 < FILL_W'(cfg.jitter_target)) begin
         limit = lat_m1;
      end else begin
         limit = FILL_W'(cfg.jitter_target);
      end

      trim       = fill_ff > limit;
      drops_trim = trim ? (fill_ff - limit) : '0;
      fill_trim  = trim ? limit : fill_ff;
      head_trim  = head_ff + drops_trim[SLOT_W-1:0];
      wslot      = head_trim + fill_trim[SLOT_W-1:0];
      ring_full  = fill_trim >= FILL_W'(QUEUE_SLOTS);
      drops_all  = drops_trim + FILL_W'(ring_full);

      apply_vol = pending_ff && (cur_vol_ff != app_vol_ff);
      hold      = buffering_ff && (fill_ff < FILL_W'(cfg.jitter_target));
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      buffering_in = buffering_ff;
      cur_vol_in   = cur_vol_ff;
      app_vol_in   = app_vol_ff;
      pending_in   = pending_ff;
      rx_cnt_in    = rx_cnt_ff;
      drop_cnt_in  = drop_cnt_ff;
      play_cnt_in  = play_cnt_ff;
      sil_cnt_in   = sil_cnt_ff;
      wr_en        = 1'b0;
      wr_entry.seq_num  = req_ff.sequence_number;
      wr_entry.byte_len = req_ff.payload_length;
      res_valid    = 1'b0;
      res_data     = '0;
      res_data.kind = KIND_REJECT;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (rsp_free) begin
               state_in  = ST_IDLE;
               res_valid = 1'b1;
               unique case (req_ff.action)
                  ACT_PACKET: begin
                     if (pkt_ok) begin
                        rx_cnt_in = rx_cnt_ff + 32'd1;
                        if (req_ff.volume_level != cur_vol_ff) begin
                           cur_vol_in = req_ff.volume_level;
                           pending_in = 1'b1;
                        end
                        head_in = head_trim;
                        fill_in = ring_full ? fill_trim : fill_trim + FILL_W'(1);
                        wr_en   = !ring_full;
                        drop_cnt_in = drop_cnt_ff + 32'(drops_all);
                        res_data.kind        = KIND_ACCEPT;
                        res_data.slot        = 4'(wslot);
                        res_data.dropped_now = 5'(drops_all);
                     end
                  end
                  ACT_TICK: begin
                     if (apply_vol) begin
                        app_vol_in = cur_vol_ff;
                        pending_in = 1'b0;
                     end
                     if (hold) begin
                        sil_cnt_in = sil_cnt_ff + 32'd1;
                        res_data.kind         = KIND_SILENCE;
                        res_data.frame_length = 16'(FRAME_BYTES);
                     end else if (fill_ff != '0) begin
                        head_in      = head_ff + SLOT_W'(1);
                        fill_in      = fill_ff - FILL_W'(1);
                        play_cnt_in  = play_cnt_ff + 32'd1;
                        buffering_in = (fill_ff == FILL_W'(1));
                        res_data.kind           = KIND_FRAME;
                        res_data.slot           = 4'(head_ff);
                        res_data.frame_length   = rd_entry.byte_len;
                        res_data.frame_sequence = rd_entry.seq_num;
                     end else begin
                        // Underrun: fall back to buffering.
                        sil_cnt_in   = sil_cnt_ff + 32'd1;
                        buffering_in = 1'b1;
                        res_data.kind         = KIND_SILENCE;
                        res_data.frame_length = 16'(FRAME_BYTES);
                     end
                  end
                  ACT_VOLUME: begin
                     if (req_ff.volume_level <= VOLUME_MAX) begin
                        cur_vol_in    = req_ff.volume_level;
                        pending_in    = 1'b1;
                        res_data.kind = KIND_ACCEPT;
                     end
                  end
                  default: begin
                     res_data.kind = KIND_REJECT;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      res_data.applied_level  = app_vol_in;
      res_data.queue_depth    = 5'(fill_in);
      res_data.received_total = rx_cnt_in;
      res_data.dropped_total  = drop_cnt_in;
      res_data.played_total   = play_cnt_in;
      res_data.silence_total  = sil_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         buffering_ff <= 1'b1;
         cur_vol_ff   <= START_VOLUME_RESET;
         app_vol_ff   <= START_VOLUME_RESET;
         pending_ff   <= 1'b0;
         rx_cnt_ff    <= '0;
         drop_cnt_ff  <= '0;
         play_cnt_ff  <= '0;
         sil_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         buffering_ff <= buffering_in;
         cur_vol_ff   <= cur_vol_in;
         app_vol_ff   <= app_vol_in;
         pending_ff   <= pending_in;
         rx_cnt_ff    <= rx_cnt_in;
         drop_cnt_ff  <= drop_cnt_in;
         play_cnt_ff  <= play_cnt_in;
         sil_cnt_ff   <= sil_cnt_in;
      end
   end

endmodule

FILE: rtl/core/audio_jitter_buffer.sv
// ----------------------------------------------------------------------------
// Audio jitter buffer
// Controller for a ring of sixteen audio frame descriptors.
// ----------------------------------------------------------------------------
// Each request is a packet arrival, a play tick or a volume override, and
// each request yields exactly one response. In the cycle a request is
// accepted the descriptor RAM reads the slot at the head of the ring, and
// in the next cycle the engine evaluates the request; once the response
// register is free it writes a new descriptor back to the RAM for an
// accepted packet and loads the response register. The engine works on
// one request at a time, so req_stall is high during the evaluation
// cycle; it stays high longer only while a finished response still
// sits unaccepted in the response register and rsp_stall holds it.
// The response register separates the two sides, so
// a new request is taken while the previous response waits. The frame
// payloads themselves live in an external buffer addressed by the reported
// slot. Configuration writes are always accepted and should only be issued
// while no request is in flight. A start volume write has no lasting effect,
// since reset restores the default start volume before it is applied.
module audio_jitter_buffer (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  ajb_pkg::req_type       req_data,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ajb_pkg::rsp_type       rsp_data,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  ajb_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata
);
   import ajb_pkg::*;

   cfg_type cfg;
   logic    rsp_free;
   logic    res_valid;
   rsp_type res_data;

   // Response register: valid flag is control state, data is payload.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   ajb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ajb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_free  (rsp_free),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // The register can take a new response when it is empty or its current
   // response leaves in this cycle.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res_data;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/ajb_checker.sv
// ----------------------------------------------------------------------------
// Audio jitter buffer checker
// Port-level assertions on the jitter buffer, attached by bind.
// ----------------------------------------------------------------------------
module ajb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ajb_pkg::rsp_type rsp_data
);
   import ajb_pkg::*;

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Only one request is in flight: an accepted request blocks the next cycle.
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in flight");

   // A played frame came from a valid packet and drops nothing.
   a_frame_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_FRAME) |->
         (rsp_data.frame_length != 16'd0) &&
         (rsp_data.frame_length <= 16'(FRAME_BYTES)) &&
         (rsp_data.dropped_now == 5'd0))
      else $error("played frame with bad length");

   // Silence carries a full frame length and no slot or sequence.
   a_silence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_SILENCE) |->
         (rsp_data.frame_length == 16'(FRAME_BYTES)) &&
         (rsp_data.slot == 4'd0) && (rsp_data.frame_sequence == 32'd0))
      else $error("malformed silence response");

endmodule

bind audio_jitter_buffer ajb_checker u_ajb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
